FILE: sv/hdmc_pkg.sv
// shared constants, codes and types of the hashed direct-mapped ttl cache
package hdmc_pkg;

  // hash, filter and ttl constants
  localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] SEEN_MULT = 32'd2654435761;
  localparam logic [31:0] TTL_RESET = 32'd120000;

  // default sizes
  localparam int DEF_SLOTS       = 256;
  localparam int DEF_SEEN_BITS   = 65536;
  localparam int DEF_MAX_PATTERN = 512;
  localparam int DEF_MAX_PAYLOAD = 8192;

  // seen filter is kept as rows of 32 bits
  localparam int SEEN_ROW_BITS = 32;
  localparam int SEEN_BIT_SEL  = 5;
  localparam int SEEN_ROW_W    = 15;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_STORE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_MISS   = 2'd1,
    OUT_REJECT = 2'd2,
    OUT_STORED = 2'd3
  } outcome_t;

  // request from the cache control to the seen filter
  typedef struct packed {
    logic                     rd_en;
    logic [SEEN_ROW_W-1:0]    rd_row;
    logic                     wr_en;
    logic [SEEN_ROW_W-1:0]    wr_row;
    logic [SEEN_ROW_BITS-1:0] wr_data;
  } seen_req_t;

endpackage

FILE: sv/hdmc_seen_filter.sv
// seen-bit filter memory with its clearing pass after reset
module hdmc_seen_filter
  import hdmc_pkg::*;
#(
  parameter int SEEN_BITS = DEF_SEEN_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  seen_req_t                req,
  output logic [SEEN_ROW_BITS-1:0] rd_row,
  output logic                     clearing
);

  localparam int ROWS = SEEN_BITS / SEEN_ROW_BITS;
  localparam int RW   = $clog2(ROWS);

  logic [SEEN_ROW_BITS-1:0] mem [ROWS];
  logic [RW-1:0]            clr_ptr_r;
  logic                     clearing_r;

  // clearing pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_ptr_r <= clr_ptr_r + RW'(1);
      if (clr_ptr_r == RW'(ROWS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // row memory, one write and one read port
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_ptr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_row[RW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_row <= mem[req.rd_row[RW-1:0]];
    end
  end

  assign clearing = clearing_r;

endmodule

FILE: sv/hashed_direct_mapped_ttl_cache_top.sv
// top level of the hashed direct-mapped ttl cache
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | in_op in_data_byte in_options ...       | beat when start && !busy
//  result  | out_outcome out_slot out_stored_len ... | one-cycle beat on out_valid
//  config  | cfg_wdata                               | write when cfg_we
//
// a pattern byte or a clear leaves busy low, so a beat may follow in the next cycle.
// a lookup or store passes a hash step (hash and memory reads) with busy high, then a
// resolve step (resolve and write back through the single slot memory port); the result
// beat is registered from the resolve step.
// after reset the seen filter is swept one 32-bit row a cycle, SEEN_BITS/32 rows
// (2048 by default), with busy high; config writes are taken meanwhile.
// results cannot be stalled: every result beat is final.
module hashed_direct_mapped_ttl_cache_top
  import hdmc_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int SEEN_BITS   = DEF_SEEN_BITS,
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_options,
  input  logic [31:0] in_table_ref,
  input  logic [31:0] in_now_ms,
  input  logic [13:0] in_compiled_len,
  output logic        out_valid,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_slot,
  output logic [12:0] out_stored_len,
  output logic        out_repeat_miss,
  output logic        out_expired,
  output logic        out_evicted,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(MAX_PATTERN + 1);
  localparam int LW  = $clog2(MAX_PATTERN);
  localparam int PW  = $clog2(MAX_PAYLOAD);
  localparam int SBW = $clog2(SEEN_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic [31:0]   hash;
    logic [LW-1:0] len;
    logic [31:0]   opts;
    logic [31:0]   tref;
    logic [31:0]   stamp;
    logic [PW-1:0] plen;
  } entry_t;

  state_t                   state_r;
  logic [31:0]              hash_r;
  logic [CW-1:0]            count_r;
  logic [31:0]              ttl_r;
  logic [31:0]              h_r;
  logic [CW-1:0]            len_r;
  op_t                      op_r;
  logic [31:0]              opts_r;
  logic [31:0]              tref_r;
  logic [31:0]              now_r;
  logic [13:0]              plen_r;
  logic [SBW-SEEN_BIT_SEL-1:0] srow_r;
  logic [SEEN_BIT_SEL-1:0]  sbit_r;
  logic [SLOTS-1:0]         slot_valid_r;
  logic [SLOTS-1:0]         slot_valid_nxt;
  entry_t                   slot_mem [SLOTS];
  entry_t                   slot_q;

  logic                     out_valid_r;
  outcome_t                 outcome_r;
  logic [7:0]               slot_r;
  logic [12:0]              stored_r;
  logic                     rep_r;
  logic                     exp_r;
  logic                     ev_r;

  logic                     accept;
  logic                     key_beat;
  op_t                      in_op_t;
  logic [31:0]              byte_nxt;
  logic [31:0]              key_nxt;
  logic [31:0]              seen_hash;
  logic [IW-1:0]            idx;

  seen_req_t                seen_req;
  logic [SEEN_ROW_BITS-1:0] seen_row;
  logic                     seen_clearing;

  // resolve results
  outcome_t                 outcome_nxt;
  logic [12:0]              stored_nxt;
  logic                     rep_nxt;
  logic                     exp_nxt;
  logic                     ev_nxt;
  logic                     slot_we;
  entry_t                   slot_wdata;
  logic                     kill_valid;
  logic                     set_valid;
  logic                     seen_we;
  logic                     len_ok;
  logic                     plen_ok;
  logic                     match;
  logic                     fresh;
  logic                     seen_bit;
  logic [31:0]              age;

  hdmc_seen_filter #(
    .SEEN_BITS(SEEN_BITS)
  ) u_seen (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (seen_req),
    .rd_row  (seen_row),
    .clearing(seen_clearing)
  );

  // handshake and hash arithmetic
  assign busy      = seen_clearing || (state_r == ST_HASH);
  assign accept    = start && !busy;
  assign in_op_t   = op_t'(in_op);
  assign key_beat  = accept && (in_op_t inside {OP_LOOKUP, OP_STORE});
  assign byte_nxt  = (hash_r ^ {24'b0, in_data_byte}) * FNV_PRIME;
  assign key_nxt   = (hash_r ^ in_options) * FNV_PRIME;
  assign seen_hash = h_r * SEEN_MULT;
  assign idx       = h_r[IW-1:0];

  // seen filter access
  always_comb begin
    seen_req.rd_en   = (state_r == ST_HASH);
    seen_req.rd_row  = SEEN_ROW_W'(seen_hash[SBW-1:SEEN_BIT_SEL]);
    seen_req.wr_en   = seen_we;
    seen_req.wr_row  = SEEN_ROW_W'(srow_r);
    seen_req.wr_data = seen_row | (SEEN_ROW_BITS'(1) << sbit_r);
  end

  // lookup and store decision on the read-back entry
  always_comb begin
    len_ok      = (len_r != '0) && (len_r < CW'(MAX_PATTERN));
    plen_ok     = (plen_r != '0) && ({1'b0, plen_r} < 15'(MAX_PAYLOAD));
    match       = slot_valid_r[idx] && (slot_q.hash == h_r) &&
                  (slot_q.len == LW'(len_r)) && (slot_q.opts == opts_r) &&
                  (slot_q.tref == tref_r);
    age         = now_r - slot_q.stamp;
    fresh       = age < ttl_r;
    seen_bit    = seen_row[sbit_r];
    outcome_nxt = OUT_REJECT;
    stored_nxt  = '0;
    rep_nxt     = 1'b0;
    exp_nxt     = 1'b0;
    ev_nxt      = 1'b0;
    slot_we     = 1'b0;
    slot_wdata  = slot_q;
    kill_valid  = 1'b0;
    set_valid   = 1'b0;
    seen_we     = 1'b0;
    if (state_r == ST_RESOLVE && len_ok) begin
      if (op_r == OP_LOOKUP) begin
        if (match && fresh) begin
          outcome_nxt      = OUT_HIT;
          stored_nxt       = 13'(slot_q.plen);
          slot_we          = 1'b1;
          slot_wdata.stamp = now_r;
        end else begin
          outcome_nxt = OUT_MISS;
          exp_nxt     = match;
          kill_valid  = match;
          rep_nxt     = seen_bit;
          seen_we     = !seen_bit;
        end
      end else if (plen_ok) begin
        outcome_nxt      = OUT_STORED;
        ev_nxt           = slot_valid_r[idx] && (slot_q.hash != h_r);
        slot_we          = 1'b1;
        set_valid        = 1'b1;
        slot_wdata.hash  = h_r;
        slot_wdata.len   = LW'(len_r);
        slot_wdata.opts  = opts_r;
        slot_wdata.tref  = tref_r;
        slot_wdata.stamp = now_r;
        slot_wdata.plen  = PW'(plen_r);
      end
    end
  end

  // valid bits: resolve update first, a clear beat on the same edge wins
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (kill_valid) begin
      slot_valid_nxt[idx] = 1'b0;
    end
    if (set_valid) begin
      slot_valid_nxt[idx] = 1'b1;
    end
    if (accept && in_op_t == OP_CLEAR) begin
      slot_valid_nxt = '0;
    end
  end

  // slot metadata memory
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[idx] <= slot_wdata;
    end
    if (state_r == ST_HASH) begin
      slot_q <= slot_mem[idx];
    end
  end

  // sequencer, pattern accumulator, valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hash_r       <= FNV_BASIS;
      count_r      <= '0;
      ttl_r        <= TTL_RESET;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      out_valid_r <= (state_r == ST_RESOLVE);
      if (state_r == ST_RESOLVE) begin
        outcome_r <= outcome_nxt;
        slot_r    <= 8'(idx);
        stored_r  <= stored_nxt;
        rep_r     <= rep_nxt;
        exp_r     <= exp_nxt;
        ev_r      <= ev_nxt;
      end
      slot_valid_r <= slot_valid_nxt;

      // a lookup or store beat is also taken while the previous item resolves
      case (state_r)
        ST_HASH: begin
          srow_r  <= seen_hash[SBW-1:SEEN_BIT_SEL];
          sbit_r  <= seen_hash[SEEN_BIT_SEL-1:0];
          state_r <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          state_r <= key_beat ? ST_HASH : ST_IDLE;
        end
        default: begin
          state_r <= key_beat ? ST_HASH : ST_IDLE;
        end
      endcase

      // new beat
      if (accept) begin
        case (in_op_t)
          OP_BYTE: begin
            hash_r <= byte_nxt;
            if (count_r < CW'(MAX_PATTERN)) begin
              count_r <= count_r + CW'(1);
            end
          end
          OP_LOOKUP, OP_STORE: begin
            h_r     <= key_nxt;
            len_r   <= count_r;
            op_r    <= in_op_t;
            opts_r  <= in_options;
            tref_r  <= in_table_ref;
            now_r   <= in_now_ms;
            plen_r  <= in_compiled_len;
            hash_r  <= FNV_BASIS;
            count_r <= '0;
          end
          default: begin
            // clear acts on the valid bits only
          end
        endcase
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_slot        = slot_r;
  assign out_stored_len  = stored_r;
  assign out_repeat_miss = rep_r;
  assign out_expired     = exp_r;
  assign out_evicted     = ev_r;

`ifndef ASSERT_OFF
  // a lookup or store beat gives its result beat once it has passed the hash and resolve steps
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    key_beat |-> ##3 out_valid)
    else $error("result beat missing after lookup or store");

  // no result without a resolve step before it
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RESOLVE))
    else $error("result beat without a resolve step");

  // the filter sweep never overlaps an item in flight
  a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    seen_clearing |-> (state_r == ST_IDLE && !seen_we && !slot_we))
    else $error("item in flight during filter sweep");

  // expiry always falls through to a miss
  a_expired_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expired) |-> (out_outcome == OUT_MISS))
    else $error("expired flag on a non-miss result");

  // eviction only reported with a completed store
  a_evict_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_outcome == OUT_STORED))
    else $error("evicted flag on a non-store result");
`endif

endmodule

FILE: test/hdmc_checker.sv
// checker for the hashed direct-mapped ttl cache: predicts each result beat and compares it
module hdmc_checker
  import hdmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_options,
  input  logic [31:0] in_table_ref,
  input  logic [31:0] in_now_ms,
  input  logic [13:0] in_compiled_len,
  input  logic        out_valid,
  input  logic [1:0]  out_outcome,
  input  logic [7:0]  out_slot,
  input  logic [12:0] out_stored_len,
  input  logic        out_repeat_miss,
  input  logic        out_expired,
  input  logic        out_evicted,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = DEF_SLOTS;
  localparam int SEEN_BITS   = DEF_SEEN_BITS;
  localparam int MAX_PATTERN = DEF_MAX_PATTERN;
  localparam int MAX_PAYLOAD = DEF_MAX_PAYLOAD;
  localparam int IW          = $clog2(SLOTS);
  localparam int SBW         = $clog2(SEEN_BITS);

  typedef struct packed {
    outcome_t    outcome;
    logic [7:0]  slot;
    logic [12:0] stored_len;
    logic        repeat_miss;
    logic        expired;
    logic        evicted;
  } lookup_result_t;

  // mirror of the cache state
  logic [31:0] ttl_limit;
  logic [31:0] pat_hash;
  logic [9:0]  pat_len;
  logic        line_valid [SLOTS];
  logic [31:0] line_hash  [SLOTS];
  logic [9:0]  line_len   [SLOTS];
  logic [31:0] line_opts  [SLOTS];
  logic [31:0] line_tref  [SLOTS];
  logic [31:0] line_stamp [SLOTS];
  logic [12:0] line_plen  [SLOTS];
  logic        seen_map   [SEEN_BITS];

  lookup_result_t due_results[$];
  int errors = 0;

  function automatic string describe_result(lookup_result_t r);
    return $sformatf("outcome %0d slot %0d stored_len %0d repeat %0b expired %0b evicted %0b",
                     r.outcome, r.slot, r.stored_len, r.repeat_miss, r.expired, r.evicted);
  endfunction

  // advance the mirror by one input beat, give the result it causes if any
  task automatic cache_predict(input op_t op, input logic [7:0] b, input logic [31:0] opts,
                               input logic [31:0] tref, input logic [31:0] now,
                               input logic [13:0] plen, output bit produced,
                               output lookup_result_t res);
    logic [31:0]    h;
    logic [31:0]    mix;
    logic [31:0]    age;
    logic [9:0]     len;
    logic [IW-1:0]  idx;
    logic [SBW-1:0] sb;
    bit             hit;
    produced = 1'b0;
    res = '0;
    case (op)
      OP_BYTE: begin
        pat_hash = (pat_hash ^ {24'd0, b}) * FNV_PRIME;
        if (pat_len < MAX_PATTERN) pat_len = pat_len + 10'd1;
      end
      OP_CLEAR: begin
        foreach (line_valid[i]) line_valid[i] = 1'b0;
      end
      default: begin
        h = (pat_hash ^ opts) * FNV_PRIME;
        len = pat_len;
        idx = h[IW-1:0];
        pat_hash = FNV_BASIS;
        pat_len = '0;
        produced = 1'b1;
        res.slot = 8'(idx);
        if (len == 0 || len >= MAX_PATTERN) begin
          res.outcome = OUT_REJECT;
        end else if (op == OP_LOOKUP) begin
          hit = 1'b0;
          if (line_valid[idx] && line_hash[idx] == h && line_len[idx] == len &&
              line_opts[idx] == opts && line_tref[idx] == tref) begin
            age = now - line_stamp[idx];
            if (age < ttl_limit) begin
              line_stamp[idx] = now;
              res.stored_len = line_plen[idx];
              hit = 1'b1;
            end else begin
              // too old: drop the entry and fall through to the miss path
              line_valid[idx] = 1'b0;
              res.expired = 1'b1;
            end
          end
          if (hit) begin
            res.outcome = OUT_HIT;
          end else begin
            mix = h * SEEN_MULT;
            sb = mix[SBW-1:0];
            res.outcome = OUT_MISS;
            if (seen_map[sb]) res.repeat_miss = 1'b1;
            else seen_map[sb] = 1'b1;
          end
        end else if (plen == 0 || plen >= MAX_PAYLOAD) begin
          res.outcome = OUT_REJECT;
        end else begin
          res.evicted = line_valid[idx] && line_hash[idx] != h;
          line_hash[idx]  = h;
          line_len[idx]   = len;
          line_opts[idx]  = opts;
          line_tref[idx]  = tref;
          line_plen[idx]  = plen[12:0];
          line_stamp[idx] = now;
          line_valid[idx] = 1'b1;
          res.outcome = OUT_STORED;
        end
      end
    endcase
  endtask

  // result beats are checked before the input beat of the same edge is predicted
  always @(posedge clk) begin : watch
    lookup_result_t want;
    lookup_result_t got;
    bit produced;
    if (!rst_n) begin
      ttl_limit = TTL_RESET;
      pat_hash = FNV_BASIS;
      pat_len = '0;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid) begin
        got.outcome     = outcome_t'(out_outcome);
        got.slot        = out_slot;
        got.stored_len  = out_stored_len;
        got.repeat_miss = out_repeat_miss;
        got.expired     = out_expired;
        got.evicted     = out_evicted;
        if (due_results.size() == 0) begin
          $display("%0t: result beat with none expected: %s", $time, describe_result(got));
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                     describe_result(want), describe_result(got));
            errors++;
          end
        end
      end
      if (cfg_we) ttl_limit = cfg_wdata;
      if (start && !busy) begin
        cache_predict(op_t'(in_op), in_data_byte, in_options, in_table_ref, in_now_ms,
                      in_compiled_len, produced, want);
        if (produced) due_results.push_back(want);
      end
    end
    pending_count <= due_results.size();
    fail_count <= errors;
  end

endmodule

FILE: test/tb_top.sv
// testbench top for the hashed direct-mapped ttl cache: stimulus, config phases and verdict
module tb_top
  import hdmc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL      = 24;
  localparam int POOL_MAX  = 10;
  localparam int PHASES    = 5;
  localparam int PHASE_LEN = 140;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = OP_BYTE;
  logic [7:0]  in_data_byte = '0;
  logic [31:0] in_options = '0;
  logic [31:0] in_table_ref = '0;
  logic [31:0] in_now_ms = '0;
  logic [13:0] in_compiled_len = '0;
  logic        out_valid;
  logic [1:0]  out_outcome;
  logic [7:0]  out_slot;
  logic [12:0] out_stored_len;
  logic        out_repeat_miss;
  logic        out_expired;
  logic        out_evicted;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;

  // pattern, options and table pools so that keys come back and hit
  logic [7:0]  pool_bytes [POOL][POOL_MAX];
  int          pool_len [POOL];
  logic [31:0] opt_pool [4];
  logic [31:0] tref_pool [3];
  logic [31:0] tick;
  int          beats_sent = 0;
  bit          burst = 1'b0;

  hashed_direct_mapped_ttl_cache_top dut (.*);
  hdmc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one input beat, then a random gap unless in a burst
  task automatic send_beat(input op_t op, input logic [7:0] b, input logic [31:0] opts,
                           input logic [31:0] tref, input logic [31:0] now,
                           input logic [13:0] plen);
    int r;
    int gap;
    start <= 1'b1;
    in_op <= op;
    in_data_byte <= b;
    in_options <= opts;
    in_table_ref <= tref;
    in_now_ms <= now;
    in_compiled_len <= plen;
    do @(posedge clk); while (busy !== 1'b0);
    beats_sent++;
    r = $urandom_range(0, 99);
    if (burst || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 20);
    else gap = $urandom_range(30, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // pattern bytes first, first+stride, ...; the other fields are noise
  task automatic feed_run(input int n, input logic [7:0] first, input logic [7:0] stride);
    for (int i = 0; i < n; i++)
      send_beat(OP_BYTE, first + 8'(i) * stride, $urandom, $urandom, $urandom, 14'($urandom));
  endtask

  task automatic feed_pool(input int k, input int n);
    for (int i = 0; i < n; i++)
      send_beat(OP_BYTE, pool_bytes[k][i], $urandom, $urandom, $urandom, 14'($urandom));
  endtask

  // hold off until every result is in and trailing byte or clear beats have settled
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] ttl_set [PHASES];
    int          adv_set [PHASES];
    logic [31:0] o0;
    logic [31:0] t0;
    logic [31:0] opts;
    logic [31:0] tref;
    logic [13:0] plen;
    op_t         op;
    int          r;
    int          k;
    int          phase_end;

    ttl_set = '{32'd0, 32'hFFFF_FFFF, 32'd200, 32'd5000, 32'd90000};
    adv_set = '{1000, 100_000_000, 150, 3000, 40000};
    foreach (pool_len[i]) begin
      pool_len[i] = $urandom_range(1, POOL_MAX);
      foreach (pool_bytes[i][j]) pool_bytes[i][j] = 8'($urandom);
    end
    foreach (tref_pool[i]) tref_pool[i] = $urandom;
    foreach (opt_pool[i]) opt_pool[i] = $urandom;
    // same slot as entry 0, different hash: forces evictions
    opt_pool[3] = opt_pool[0] ^ 32'h0001_0000;
    o0 = 32'h1234_5678;
    t0 = 32'h0000_00A5;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty patterns are rejected
    send_beat(OP_LOOKUP, 8'($urandom), 32'd0, 32'd0, 32'd0, 14'd0);
    send_beat(OP_STORE, 8'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'd100);
    // cold miss, repeat miss, store, hit just inside the ttl
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd1000, 14'd0);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd1000, 14'd0);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd1000, 14'd1);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd120999, 14'd0);
    // table mismatch, then age equal to the ttl expires the entry
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0 ^ 32'd1, 32'd121000, 14'd0);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd240999, 14'd0);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd241000, 14'd0);
    // bad payload lengths
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd250000, 14'd0);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd250000, 14'd8192);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd250000, 14'd16383);
    // overwrite with same hash, then a same-slot store with another hash evicts
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd250000, 14'd8191);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd250000, 14'd8191);
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_STORE, 8'h00, o0 ^ 32'h0000_0100, t0, 32'd250000, 14'd77);
    send_beat(OP_CLEAR, 8'($urandom), $urandom, $urandom, $urandom, 14'($urandom));
    feed_run(3, 8'h41, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0 ^ 32'h0000_0100, t0, 32'd250000, 14'd0);
    // field extremes and a now_ms that wraps between store and hit
    feed_run(1, 8'h00, 8'h00);
    send_beat(OP_STORE, 8'h00, 32'd0, 32'd0, 32'hFFFF_FF00, 14'd5);
    feed_run(1, 8'h00, 8'h00);
    send_beat(OP_LOOKUP, 8'h00, 32'd0, 32'd0, 32'h0000_0010, 14'd0);
    feed_run(2, 8'hFF, 8'h00);
    send_beat(OP_STORE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'd8191);
    feed_run(2, 8'hFF, 8'h00);
    send_beat(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'd0);
    // a clear in the middle of a pattern keeps the accumulator
    feed_run(2, 8'h10, 8'h01);
    send_beat(OP_CLEAR, 8'($urandom), $urandom, $urandom, $urandom, 14'($urandom));
    feed_run(2, 8'h12, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd300000, 14'd9);
    feed_run(4, 8'h10, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd300001, 14'd0);
    // longest accepted pattern, then the length limit
    burst = 1'b1;
    feed_run(511, 8'h00, 8'h01);
    send_beat(OP_STORE, 8'h00, o0, t0, 32'd500000, 14'd300);
    feed_run(512, 8'h00, 8'h01);
    send_beat(OP_LOOKUP, 8'h00, o0, t0, 32'd500000, 14'd0);
    burst = 1'b0;

    // random phases, one ttl setting each
    tick = 32'd600000;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_ttl(ttl_set[p]);
      phase_end = beats_sent + PHASE_LEN;
      while (beats_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          // well-formed key from the pools
          k = $urandom_range(0, POOL - 1);
          feed_pool(k, pool_len[k]);
          tick = tick + $urandom_range(0, adv_set[p]);
          op = ($urandom_range(0, 9) < 6) ? OP_LOOKUP : OP_STORE;
          opts = opt_pool[$urandom_range(0, 3)];
          tref = ($urandom_range(0, 9) == 0) ? $urandom : tref_pool[$urandom_range(0, 2)];
          if ($urandom_range(0, 19) != 0) plen = 14'($urandom_range(1, 8191));
          else if ($urandom_range(0, 1) == 0) plen = 14'd0;
          else plen = 14'($urandom_range(8192, 16383));
          send_beat(op, 8'($urandom), opts, tref, tick, plen);
        end else if (r < 80) begin
          // noise: a few bytes and any op with any fields
          repeat ($urandom_range(0, 4))
            send_beat(OP_BYTE, 8'($urandom), $urandom, $urandom, $urandom, 14'($urandom));
          send_beat(op_t'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom, $urandom,
                    14'($urandom));
        end else if (r < 86) begin
          // broken key: a prefix of a pool pattern (possibly all of it) or none at all
          k = $urandom_range(0, POOL - 1);
          if ($urandom_range(0, 1) == 0) feed_pool(k, $urandom_range(1, pool_len[k]));
          op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_STORE;
          send_beat(op, 8'($urandom), opt_pool[$urandom_range(0, 3)],
                    tref_pool[$urandom_range(0, 2)], tick, 14'($urandom_range(1, 8191)));
        end else if (r < 88) begin
          send_beat(OP_CLEAR, 8'($urandom), $urandom, $urandom, $urandom, 14'($urandom));
        end else if (r < 93) begin
          wait_idle();
        end else begin
          burst = !burst;
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/hdmc_pkg.sv
sv/hdmc_seen_filter.sv
sv/hashed_direct_mapped_ttl_cache_top.sv
test/hdmc_checker.sv
test/tb_top.sv
